FILE: src/fcss_pkg.sv
package fcss_pkg;

  // Width of the saturating pulse counter.
  localparam int COUNT_WIDTH = 20;

  localparam int GATE_WIDTH  = 16;
  localparam int DWELL_WIDTH = 8;
  localparam int VALUE_WIDTH = 10;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [GATE_WIDTH-1:0]  GATE_RESET  = GATE_WIDTH'(1000);
  localparam logic [DWELL_WIDTH-1:0] DWELL_RESET = DWELL_WIDTH'(6);
  localparam logic [VALUE_WIDTH-1:0] SHOW_MAX    = VALUE_WIDTH'(999);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GATE_MS  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DWELL_MS = 1'b1;

  typedef struct packed {
    logic signal_level;
    logic ms_tick;
  } fcss_in_t;

  typedef struct packed {
    logic [6:0]             segments;
    logic [2:0]             digit_enable;
    logic [VALUE_WIDTH-1:0] shown_value;
    logic                   overflow;
    logic                   fresh;
  } fcss_out_t;

  // Measurement state after the current item, from the gate unit.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   overflow;
    logic                   fresh;
  } fcss_meas_t;

  // Display drive after the current item, from the scan unit.
  typedef struct packed {
    logic [6:0] segments;
    logic [2:0] digit_enable;
  } fcss_disp_t;

endpackage

FILE: src/fcss_gate.sv
module fcss_gate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  fcss_pkg::fcss_in_t                  sample,
  input  logic [fcss_pkg::GATE_WIDTH-1:0]     gate_ms,
  output fcss_pkg::fcss_meas_t                meas
);

  localparam logic [fcss_pkg::COUNT_WIDTH-1:0] COUNT_MAX = {fcss_pkg::COUNT_WIDTH{1'b1}};

  logic                                prev_level;
  logic [fcss_pkg::COUNT_WIDTH-1:0]    pulse_count;
  logic [fcss_pkg::COUNT_WIDTH-1:0]    pulse_count_next;
  logic [fcss_pkg::COUNT_WIDTH-1:0]    pulse_counted;
  logic [fcss_pkg::GATE_WIDTH-1:0]     gate_count;
  logic [fcss_pkg::GATE_WIDTH-1:0]     gate_count_next;
  logic [fcss_pkg::GATE_WIDTH:0]       gate_inc;
  logic [fcss_pkg::GATE_WIDTH:0]       gate_len;
  logic [fcss_pkg::VALUE_WIDTH-1:0]    latched_value;
  logic                                overflow_flag;
  logic                                gate_done;

  always_comb begin
    // The falling edge of this item is counted before the gate may close.
    if (prev_level && !sample.signal_level && pulse_count != COUNT_MAX) begin
      pulse_counted = pulse_count + 1'b1;
    end else begin
      pulse_counted = pulse_count;
    end

    gate_len  = (gate_ms == '0) ? (fcss_pkg::GATE_WIDTH+1)'(1) : {1'b0, gate_ms};
    gate_inc  = {1'b0, gate_count} + 1'b1;
    gate_done = sample.ms_tick && (gate_inc >= gate_len);

    pulse_count_next = gate_done ? '0 : pulse_counted;
    if (gate_done) begin
      gate_count_next = '0;
    end else if (sample.ms_tick) begin
      gate_count_next = gate_inc[fcss_pkg::GATE_WIDTH-1:0];
    end else begin
      gate_count_next = gate_count;
    end

    meas.value    = latched_value;
    meas.overflow = overflow_flag;
    meas.fresh    = gate_done;
    if (gate_done) begin
      if (pulse_counted > fcss_pkg::COUNT_WIDTH'(fcss_pkg::SHOW_MAX)) begin
        meas.value    = fcss_pkg::SHOW_MAX;
        meas.overflow = 1'b1;
      end else begin
        meas.value    = pulse_counted[fcss_pkg::VALUE_WIDTH-1:0];
        meas.overflow = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level    <= 1'b0;
      pulse_count   <= '0;
      gate_count    <= '0;
      latched_value <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      prev_level    <= sample.signal_level;
      pulse_count   <= pulse_count_next;
      gate_count    <= gate_count_next;
      latched_value <= meas.value;
      overflow_flag <= meas.overflow;
    end
  end

  a_value_capped: assert property (@(posedge clk) disable iff (rst)
    latched_value <= fcss_pkg::SHOW_MAX)
    else $error("latched value above display range");

  a_overflow_shows_max: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> latched_value == fcss_pkg::SHOW_MAX)
    else $error("overflow set without saturated value");

  a_gate_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && gate_done |=> gate_count == '0 && pulse_count == '0)
    else $error("counters not restarted at gate end");

endmodule

FILE: src/fcss_scan.sv
module fcss_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                ms_tick,
  input  logic [fcss_pkg::DWELL_WIDTH-1:0]    dwell_ms,
  input  logic [fcss_pkg::VALUE_WIDTH-1:0]    value,
  output fcss_pkg::fcss_disp_t                disp
);

  logic [fcss_pkg::DWELL_WIDTH-1:0] dwell_count;
  logic [fcss_pkg::DWELL_WIDTH-1:0] dwell_count_next;
  logic [fcss_pkg::DWELL_WIDTH:0]   dwell_inc;
  logic [fcss_pkg::DWELL_WIDTH:0]   dwell_len;
  logic [1:0]                       digit_index;
  logic [1:0]                       digit_index_next;
  logic [15:0]                      hund_prod;
  logic [3:0]                       hund;
  logic [9:0]                       hund_part;
  logic [6:0]                       rem;
  logic [14:0]                      tens_prod;
  logic [3:0]                       tens;
  logic [3:0]                       units;

  function automatic logic [6:0] seg_font(input logic [3:0] digit);
    logic [6:0] pattern;
    unique case (digit)
      4'd0:    pattern = 7'h3F;
      4'd1:    pattern = 7'h06;
      4'd2:    pattern = 7'h5B;
      4'd3:    pattern = 7'h4F;
      4'd4:    pattern = 7'h66;
      4'd5:    pattern = 7'h6D;
      4'd6:    pattern = 7'h7D;
      4'd7:    pattern = 7'h07;
      4'd8:    pattern = 7'h7F;
      4'd9:    pattern = 7'h6F;
      default: pattern = 7'h00;
    endcase
    return pattern;
  endfunction

  always_comb begin
    dwell_len = (dwell_ms == '0) ? (fcss_pkg::DWELL_WIDTH+1)'(1) : {1'b0, dwell_ms};
    dwell_inc = {1'b0, dwell_count} + 1'b1;
    dwell_count_next = dwell_count;
    digit_index_next = digit_index;
    if (ms_tick) begin
      if (dwell_inc >= dwell_len) begin
        dwell_count_next = '0;
        digit_index_next = (digit_index >= 2'd2) ? 2'd0 : digit_index + 2'd1;
      end else begin
        dwell_count_next = dwell_inc[fcss_pkg::DWELL_WIDTH-1:0];
      end
    end

    // Decimal split by reciprocal multiplication; exact for values up to 999.
    hund_prod = 16'(value) * 16'd41;
    hund      = hund_prod[15:12];
    hund_part = 10'(hund) * 10'd100;
    rem       = 7'(value - hund_part);
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    units     = 4'(rem - 7'(tens) * 7'd10);

    unique case (digit_index_next)
      2'd0: begin
        disp.segments     = seg_font(hund);
        disp.digit_enable = 3'b001;
      end
      2'd1: begin
        disp.segments     = seg_font(tens);
        disp.digit_enable = 3'b010;
      end
      2'd2: begin
        disp.segments     = seg_font(units);
        disp.digit_enable = 3'b100;
      end
      default: begin
        disp.segments     = 7'h00;
        disp.digit_enable = 3'b000;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_count <= '0;
      digit_index <= 2'd0;
    end else if (accept) begin
      dwell_count <= dwell_count_next;
      digit_index <= digit_index_next;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    digit_index != 2'd3)
    else $error("unused digit index reached");

  a_hold_without_tick: assert property (@(posedge clk) disable iff (rst)
    accept && !ms_tick |=> $stable(digit_index) && $stable(dwell_count))
    else $error("scan advanced without a strobe");

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(disp.digit_enable))
    else $error("digit select not one-hot");

endmodule

FILE: src/frequency_counter_seven_segment.sv
// Channel | Direction | Handshake                   | Payload
// sample  | in        | sample_valid / sample_ready | fcss_in_t  (signal_level, ms_tick)
// result  | out       | result_valid / result_ready | fcss_out_t (segments .. fresh)
// cfg     | in        | cfg_we                      | cfg_index, cfg_data
//
// One item per clock unless the result side stalls: each accepted item updates the
// counters and display scan in the same cycle, and its result is held in the output
// register the next cycle. sample_ready is high whenever the output register is
// empty or being drained, so a stall on the result side holds back the input.
// rst is synchronous; it clears all counters and loads gate_ms 1000, dwell_ms 6.
module frequency_counter_seven_segment (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  fcss_pkg::fcss_in_t                    sample,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output fcss_pkg::fcss_out_t                   result,
  input  logic                                  cfg_we,
  input  logic [fcss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [fcss_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  logic [fcss_pkg::GATE_WIDTH-1:0]  gate_ms;
  logic [fcss_pkg::DWELL_WIDTH-1:0] dwell_ms;
  logic                             accept;
  fcss_pkg::fcss_meas_t             meas;
  fcss_pkg::fcss_disp_t             disp;
  fcss_pkg::fcss_out_t              result_next;

  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_ms  <= fcss_pkg::GATE_RESET;
      dwell_ms <= fcss_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == fcss_pkg::REG_GATE_MS) begin
        gate_ms <= cfg_data[fcss_pkg::GATE_WIDTH-1:0];
      end else if (cfg_index == fcss_pkg::REG_DWELL_MS) begin
        dwell_ms <= cfg_data[fcss_pkg::DWELL_WIDTH-1:0];
      end
    end
  end

  fcss_gate u_gate (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sample  (sample),
    .gate_ms (gate_ms),
    .meas    (meas)
  );

  fcss_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ms_tick  (sample.ms_tick),
    .dwell_ms (dwell_ms),
    .value    (meas.value),
    .disp     (disp)
  );

  always_comb begin
    result_next.segments     = disp.segments;
    result_next.digit_enable = disp.digit_enable;
    result_next.shown_value  = meas.value;
    result_next.overflow     = meas.overflow;
    result_next.fresh        = meas.fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("input blocked with empty output register");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.shown_value <= fcss_pkg::SHOW_MAX
                     && $onehot0(result.digit_enable))
    else $error("result outside display range");

endmodule
